[hdl/rmq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg: shared constants, types and helpers
// Fixed-point widths, stage counts and the output clamp for the rotation
// matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int EL_W      = 16;
  localparam int NUM_EL    = 9;
  localparam int IN_W      = NUM_EL * EL_W;
  localparam int OUT_W     = 4 * EL_W;
  localparam int USER_W    = 3;

  localparam int ONE       = 1 << FRAC_BITS;
  localparam int EL_POS    = (1 << (EL_W - 1)) - 1;
  localparam int EL_NEG    = 1 << (EL_W - 1);
  localparam int POS_MAX   = (ONE > EL_POS) ? EL_POS : ONE;
  localparam int NEG_MAX   = (ONE > EL_NEG) ? EL_NEG : ONE;

  // candidate sums and the shifted largest candidate
  localparam int CAND_W    = EL_W + 2;
  localparam int ONE_W     = FRAC_BITS + 2;
  localparam int S_W       = ((CAND_W > ONE_W) ? CAND_W : ONE_W) + 1;

  // square root
  localparam int SQ_IN_W   = S_W - 1 + FRAC_BITS;
  localparam int SQ_RW     = (SQ_IN_W + 1) / 2;
  localparam int SQ_PAD_W  = 2 * SQ_RW;
  localparam int SQ_REM_W  = SQ_RW + 2;
  localparam int SQ_LAT    = SQ_RW;
  localparam int V_W       = SQ_RW - 1;
  localparam int DEN_W     = SQ_RW + 1;

  // divider
  localparam int D_W       = EL_W + 1;
  localparam int N_W       = D_W + FRAC_BITS + 1;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int HI_W      = N_W - Q_W;
  localparam int CMP_W     = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;
  localparam int DIV_LAT   = Q_W + 1;

  // front end: two stages, back end: one setup stage before the divider
  localparam int PIPE_N    = 2 + SQ_LAT + 1 + DIV_LAT;

  localparam int MAG_A     = (Q_W > V_W) ? Q_W : V_W;
  localparam int MAG_W     = ((MAG_A > EL_W) ? MAG_A : EL_W) + 1;

  localparam logic [1:0] IDX_W = 2'd0;
  localparam logic [1:0] IDX_X = 2'd1;
  localparam logic [1:0] IDX_Y = 2'd2;
  localparam logic [1:0] IDX_Z = 2'd3;

  typedef struct packed {
    logic           sat;
    logic [Q_W-1:0] q;
  } div_res_t;

  // limit a magnitude to one (and to the element range), then apply sign
  function automatic logic [EL_W-1:0] sat_comp(input logic             force_lim,
                                              input logic [MAG_W-1:0] mag,
                                              input logic             neg);
    logic [MAG_W-1:0] lim;
    logic [MAG_W-1:0] m;
    lim = neg ? MAG_W'(NEG_MAX) : MAG_W'(POS_MAX);
    m   = (force_lim || (mag > lim)) ? lim : mag;
    return neg ? EL_W'(-m) : EL_W'(m);
  endfunction

endpackage
`default_nettype wire

[hdl/rotation_matrix_to_quaternion.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion
// Picks the largest quaternion component from the diagonal, takes its square
// root, and divides the off-diagonal terms by four times that component.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per matrix, nine signed Q1.14 elements, row major.
//   out_* : one word per matrix, w/x/y/z in signed Q1.14 (clamped to +-1),
//           plus the chosen component index and a degenerate flag in tuser.
// Throughput: one word per cycle while in_tready is high, no gaps between
//   back-to-back words.
// Depth: 36 register stages (2 front-end + 16 square-root + 1 setup
//   + 16 divider + output register).
//   The square root (one bit per stage) and the three parallel dividers
//   (one quotient bit per stage) set the depth.
// Stall: the whole pipe advances on one enable. A two-entry output buffer
//   (output register plus skid) keeps taking words while a result waits;
//   in_tready drops only once the skid entry is also full, and is driven
//   from a flop.
// Reset: synchronous, active low; clears all valid bits, so the pipe and
//   the output buffer come up empty. No other state.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  logic                       clk,
  input  logic                       rst_n,
  // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (16 bits each)
  input  logic [rmq_pkg::IN_W-1:0]   in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each)
  output logic [rmq_pkg::OUT_W-1:0]  out_tdata,
  // largest_index [1:0], degenerate [2]
  output logic [rmq_pkg::USER_W-1:0] out_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready
);
  import rmq_pkg::*;

  typedef struct packed {
    logic [1:0]            idx;
    logic                  degen;
    logic signed [D_W-1:0] d0;
    logic signed [D_W-1:0] d1;
    logic signed [D_W-1:0] d2;
  } sq_side_t;

  typedef struct packed {
    logic [1:0]     idx;
    logic           degen;
    logic [2:0]     neg;
    logic [V_W-1:0] v;
  } dv_side_t;

  // pipeline control
  logic              en;
  logic [PIPE_N-1:0] vld_r;
  logic              last_v;

  // ---------------- stage A: candidates and off-diagonal terms -------------
  logic signed [EL_W-1:0]   m [NUM_EL];
  logic signed [CAND_W-1:0] cand_nxt [4];
  logic signed [CAND_W-1:0] cand_a_r [4];
  logic signed [D_W-1:0]    dwx_nxt, dwy_nxt, dwz_nxt, sxy_nxt, sxz_nxt, syz_nxt;
  logic signed [D_W-1:0]    dwx_a_r, dwy_a_r, dwz_a_r, sxy_a_r, sxz_a_r, syz_a_r;

  always_comb begin
    for (int i = 0; i < NUM_EL; i++) begin
      m[i] = in_tdata[i*EL_W +: EL_W];
    end
  end

  // element order: 0 r0c0, 1 r0c1, 2 r0c2, 3 r1c0, 4 r1c1, 5 r1c2, 6..8 row 2
  assign cand_nxt[0] = CAND_W'(m[0]) + CAND_W'(m[4]) + CAND_W'(m[8]);
  assign cand_nxt[1] = CAND_W'(m[0]) - CAND_W'(m[4]) - CAND_W'(m[8]);
  assign cand_nxt[2] = CAND_W'(m[4]) - CAND_W'(m[0]) - CAND_W'(m[8]);
  assign cand_nxt[3] = CAND_W'(m[8]) - CAND_W'(m[0]) - CAND_W'(m[4]);

  assign dwx_nxt = D_W'(m[7]) - D_W'(m[5]);
  assign dwy_nxt = D_W'(m[2]) - D_W'(m[6]);
  assign dwz_nxt = D_W'(m[3]) - D_W'(m[1]);
  assign sxy_nxt = D_W'(m[3]) + D_W'(m[1]);
  assign sxz_nxt = D_W'(m[2]) + D_W'(m[6]);
  assign syz_nxt = D_W'(m[7]) + D_W'(m[5]);

  always_ff @(posedge clk) begin
    if (en) begin
      cand_a_r <= cand_nxt;
      dwx_a_r  <= dwx_nxt;
      dwy_a_r  <= dwy_nxt;
      dwz_a_r  <= dwz_nxt;
      sxy_a_r  <= sxy_nxt;
      sxz_a_r  <= sxz_nxt;
      syz_a_r  <= syz_nxt;
    end
  end

  // ---------------- stage B: pick largest, radicand, lane routing ----------
  logic signed [CAND_W-1:0] best;
  logic [1:0]               idx_nxt;
  logic signed [S_W-1:0]    s_nxt;
  logic                     degen_nxt;
  logic [SQ_PAD_W-1:0]      sqin_nxt;
  logic [SQ_PAD_W-1:0]      sqin_b_r;
  sq_side_t                 side_b_nxt;
  sq_side_t                 side_b_r;

  // strict compares: earliest candidate wins a tie
  always_comb begin
    best    = cand_a_r[0];
    idx_nxt = IDX_W;
    if (cand_a_r[1] > best) begin
      best    = cand_a_r[1];
      idx_nxt = IDX_X;
    end
    if (cand_a_r[2] > best) begin
      best    = cand_a_r[2];
      idx_nxt = IDX_Y;
    end
    if (cand_a_r[3] > best) begin
      best    = cand_a_r[3];
      idx_nxt = IDX_Z;
    end
  end

  assign s_nxt     = S_W'(best) + S_W'(ONE);
  assign degen_nxt = s_nxt[S_W-1] || (s_nxt == '0);
  assign sqin_nxt  = degen_nxt ? '0
                   : SQ_PAD_W'({s_nxt[S_W-2:0], {FRAC_BITS{1'b0}}});

  // lanes 0..2 cover the three other components in w, x, y, z order
  always_comb begin
    side_b_nxt.idx   = idx_nxt;
    side_b_nxt.degen = degen_nxt;
    unique case (idx_nxt)
      IDX_W: begin
        side_b_nxt.d0 = dwx_a_r;
        side_b_nxt.d1 = dwy_a_r;
        side_b_nxt.d2 = dwz_a_r;
      end
      IDX_X: begin
        side_b_nxt.d0 = dwx_a_r;
        side_b_nxt.d1 = sxy_a_r;
        side_b_nxt.d2 = sxz_a_r;
      end
      IDX_Y: begin
        side_b_nxt.d0 = dwy_a_r;
        side_b_nxt.d1 = sxy_a_r;
        side_b_nxt.d2 = syz_a_r;
      end
      IDX_Z: begin
        side_b_nxt.d0 = dwz_a_r;
        side_b_nxt.d1 = sxz_a_r;
        side_b_nxt.d2 = syz_a_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqin_b_r <= sqin_nxt;
      side_b_r <= side_b_nxt;
    end
  end

  // ---------------- square root, side data delayed alongside ---------------
  logic [SQ_RW-1:0] root;
  sq_side_t         sq_side_r [SQ_LAT];

  rmq_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .x    (sqin_b_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= side_b_r;
      for (int i = 1; i < SQ_LAT; i++) begin
        sq_side_r[i] <= sq_side_r[i-1];
      end
    end
  end

  // ---------------- stage C: denominator, rounded dividends ----------------
  sq_side_t              sq_out;
  logic [V_W-1:0]        v;
  logic [DEN_W-1:0]      den_nxt;
  logic signed [D_W-1:0] d_lane [3];
  logic [2:0]            neg_nxt;
  logic [N_W-1:0]        num_nxt [3];
  logic [N_W-1:0]        num_c_r [3];
  logic [DEN_W-1:0]      den_c_r;
  dv_side_t              side_c_r;

  assign sq_out    = sq_side_r[SQ_LAT-1];
  assign v         = root[SQ_RW-1:1];
  assign den_nxt   = {v, 2'b00};
  assign d_lane[0] = sq_out.d0;
  assign d_lane[1] = sq_out.d1;
  assign d_lane[2] = sq_out.d2;

  // |d| * 2^F + den/2, so the truncating divider rounds half away from zero;
  // widen before negating so the most negative sum keeps its magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i] = d_lane[i][D_W-1];
      num_nxt[i] = ((neg_nxt[i] ? -N_W'(d_lane[i]) : N_W'(d_lane[i])) << FRAC_BITS)
                 + N_W'(den_nxt >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_c_r        <= num_nxt;
      den_c_r        <= den_nxt;
      side_c_r.idx   <= sq_out.idx;
      side_c_r.degen <= sq_out.degen;
      side_c_r.neg   <= neg_nxt;
      side_c_r.v     <= v;
    end
  end

  // ---------------- dividers, side data delayed alongside ------------------
  div_res_t dres [3];
  dv_side_t dv_side_r [DIV_LAT];

  for (genvar g = 0; g < 3; g++) begin : g_div
    rmq_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_c_r[g]),
      .den (den_c_r),
      .res (dres[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0] <= side_c_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv_side_r[i] <= dv_side_r[i-1];
      end
    end
  end

  // ---------------- result assembly ----------------------------------------
  dv_side_t               dv_out;
  logic [EL_W-1:0]        lane_q [3];
  logic [EL_W-1:0]        big_q;
  logic [EL_W-1:0]        qw, qx, qy, qz;
  logic [OUT_W-1:0]       res_data;
  logic [USER_W-1:0]      res_user;

  assign dv_out = dv_side_r[DIV_LAT-1];
  assign big_q  = sat_comp(1'b0, MAG_W'(dv_out.v), 1'b0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_q[i] = sat_comp(dres[i].sat, MAG_W'(dres[i].q), dv_out.neg[i]);
    end
  end

  always_comb begin
    unique case (dv_out.idx)
      IDX_W: begin
        qw = big_q;     qx = lane_q[0]; qy = lane_q[1]; qz = lane_q[2];
      end
      IDX_X: begin
        qw = lane_q[0]; qx = big_q;     qy = lane_q[1]; qz = lane_q[2];
      end
      IDX_Y: begin
        qw = lane_q[0]; qx = lane_q[1]; qy = big_q;     qz = lane_q[2];
      end
      IDX_Z: begin
        qw = lane_q[0]; qx = lane_q[1]; qy = lane_q[2]; qz = big_q;
      end
    endcase
  end

  assign res_data = dv_out.degen ? '0 : {qz, qy, qx, qw};
  assign res_user = {dv_out.degen, dv_out.idx};

  // ---------------- valid chain and output buffer --------------------------
  logic                out_valid_r, out_valid_nxt;
  logic                skid_v_r, skid_v_nxt;
  logic [OUT_W-1:0]    out_data_r, skid_data_r;
  logic [USER_W-1:0]   out_user_r, skid_user_r;
  logic                load_out, load_skid;

  assign last_v    = vld_r[PIPE_N-1];
  assign en        = !skid_v_r;
  assign in_tready = en;

  // skid holds a word only while the output register is also full
  assign load_out  = skid_v_r ? out_tready : (last_v && (!out_valid_r || out_tready));
  assign load_skid = !skid_v_r && last_v && out_valid_r && !out_tready;

  assign out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign skid_v_nxt    = load_skid ? 1'b1 : ((skid_v_r && out_tready) ? 1'b0 : skid_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[PIPE_N-2:0], in_tvalid};
      end
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= skid_v_r ? skid_data_r : res_data;
      out_user_r <= skid_v_r ? skid_user_r : res_user;
    end
    if (load_skid) begin
      skid_data_r <= res_data;
      skid_user_r <= res_user;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  // ---------------- assertions ---------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_v_r && last_v && out_valid_r && !out_tready) |=> skid_v_r)
    else $error("finished word not caught by skid entry");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tdata == '0))
    else $error("degenerate word with nonzero components");

  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[EL_W-1:0]) <= ONE) && ($signed(out_tdata[EL_W-1:0]) >= -ONE) &&
      ($signed(out_tdata[2*EL_W-1:EL_W]) <= ONE) &&
      ($signed(out_tdata[2*EL_W-1:EL_W]) >= -ONE) &&
      ($signed(out_tdata[3*EL_W-1:2*EL_W]) <= ONE) &&
      ($signed(out_tdata[3*EL_W-1:2*EL_W]) >= -ONE) &&
      ($signed(out_tdata[4*EL_W-1:3*EL_W]) <= ONE) &&
      ($signed(out_tdata[4*EL_W-1:3*EL_W]) >= -ONE))
    else $error("quaternion component outside +-1");

endmodule
`default_nettype wire

[hdl/rmq_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_isqrt: pipelined integer square root
// Floor square root, one result bit per stage, SQ_LAT stages, global enable.
// ----------------------------------------------------------------------------
module rmq_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rmq_pkg::SQ_PAD_W-1:0] x,
  output logic [rmq_pkg::SQ_RW-1:0]    root
);
  import rmq_pkg::*;

  logic [SQ_REM_W-1:0] rem_r  [SQ_RW];
  logic [SQ_RW-1:0]    root_r [SQ_RW];
  logic [SQ_PAD_W-1:0] x_r    [SQ_RW];

  for (genvar k = 0; k < SQ_RW; k++) begin : g_st
    logic [SQ_REM_W-1:0] rem_in;
    logic [SQ_RW-1:0]    root_in;
    logic [SQ_PAD_W-1:0] x_in;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
    end

    // bring down the next two radicand bits, try (4*root + 1)
    assign rem_sh = {rem_in[SQ_RW-1:0], x_in[SQ_PAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_in[SQ_RW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_in[SQ_RW-2:0], 1'b0};
        end
        x_r[k] <= x_in << 2;
      end
    end
  end

  assign root = root_r[SQ_RW-1];

endmodule
`default_nettype wire

[hdl/rmq_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div: pipelined restoring divider with saturation
// Overflow check in the setup stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rmq_pkg::N_W-1:0]   num,
  input  logic [rmq_pkg::DEN_W-1:0] den,
  output rmq_pkg::div_res_t         res
);
  import rmq_pkg::*;

  logic [DEN_W-1:0] rem_r [DIV_LAT];
  logic [Q_W-1:0]   lo_r  [DIV_LAT];
  logic [Q_W-1:0]   q_r   [DIV_LAT];
  logic [DEN_W-1:0] den_r [DIV_LAT];
  logic             sat_r [DIV_LAT];

  logic [HI_W-1:0]  hi;
  logic             sat_nxt;

  // quotient would need more than Q_W bits
  assign hi      = num[N_W-1 -: HI_W];
  assign sat_nxt = CMP_W'(hi) >= CMP_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= sat_nxt ? '0 : DEN_W'(hi);
      lo_r[0]  <= num[Q_W-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
      sat_r[0] <= sat_nxt;
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_st
    logic [DEN_W:0] rem_sh;

    assign rem_sh = {rem_r[k-1], lo_r[k-1][Q_W-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= {1'b0, den_r[k-1]}) begin
          rem_r[k] <= DEN_W'(rem_sh - {1'b0, den_r[k-1]});
          q_r[k]   <= {q_r[k-1][Q_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= DEN_W'(rem_sh);
          q_r[k]   <= {q_r[k-1][Q_W-2:0], 1'b0};
        end
        lo_r[k]  <= lo_r[k-1] << 1;
        den_r[k] <= den_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  assign res.sat = sat_r[DIV_LAT-1];
  assign res.q   = q_r[DIV_LAT-1];

endmodule
`default_nettype wire
